[src/cfm_pkg.sv]
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared constants, fixed-point weights and types of the crop feature map.
// ----------------------------------------------------------------------------
package cfm_pkg;

  localparam int FRAC_BITS = 15;
  localparam int MAX_WIDTH = 2048;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = 16;

  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

  // rec.709 luma weights, rounded to FRAC_BITS
  localparam longint unsigned LUMA_WR_Q = ((64'd2126 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned LUMA_WG_Q = ((64'd7152 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned LUMA_WB_Q = ((64'd722 << FRAC_BITS) + 64'd5000) / 64'd10000;

  // reference skin color direction
  localparam longint unsigned SKIN_KR_Q = ((64'd78 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned SKIN_KG_Q = ((64'd57 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned SKIN_KB_Q = ((64'd44 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned SKIN_KK_Q =
    (SKIN_KR_Q * SKIN_KR_Q + SKIN_KG_Q * SKIN_KG_Q + SKIN_KB_Q * SKIN_KB_Q
     + (ONE_Q >> 1)) >> FRAC_BITS;
  localparam longint unsigned KK_PLUS_ONE_Q = SKIN_KK_Q + ONE_Q;

  localparam int LUMA_SUM_W = FRAC_BITS + 9;
  localparam int DOT_W      = FRAC_BITS + 9;
  localparam int M2_W       = 18;
  localparam int DIV_NW     = 2 * FRAC_BITS + 9;
  localparam int DIV_DW     = FRAC_BITS + 9;
  localparam int SQ_IN_W    = 2 * FRAC_BITS + M2_W;
  localparam int SQ_W       = SQ_IN_W / 2;
  localparam int U_W        = FRAC_BITS + 2;
  localparam int D2_W       = FRAC_BITS + 4;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_SAT_THRESHOLD  = 3'd2,
    REG_SKIN_THRESHOLD = 3'd3,
    REG_SAT_LUMA_MIN   = 3'd4,
    REG_SAT_LUMA_MAX   = 3'd5,
    REG_SKIN_LUMA_MIN  = 3'd6,
    REG_SKIN_LUMA_MAX  = 3'd7
  } cfm_reg_t;

  typedef struct packed {
    logic [7:0] sat_threshold;
    logic [7:0] skin_threshold;
    logic [7:0] sat_luma_min;
    logic [7:0] sat_luma_max;
    logic [7:0] skin_luma_min;
    logic [7:0] skin_luma_max;
  } cfm_cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] skin;
    logic [7:0] sat;
  } cfm_feat_t;

  typedef struct packed {
    logic [7:0] above;
    logic [7:0] center;
    logic [7:0] skin;
    logic [7:0] sat;
  } cfm_line_word_t;

endpackage

[src/cfm_divider.sv]
// ----------------------------------------------------------------------------
// cfm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfm_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cfm_pkg::DIV_NW-1:0]   dividend,
  input  logic [cfm_pkg::DIV_DW-1:0]   divisor,
  output logic                         done,
  output logic [cfm_pkg::DIV_NW-1:0]   quotient
);

  localparam int NW    = cfm_pkg::DIV_NW;
  localparam int DW    = cfm_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DW:0]      rem;
  logic [DW-1:0]    den;
  logic [DW:0]      rem_shift;
  logic             take;

  assign rem_shift = {rem[DW-1:0], quotient[NW-1]};
  assign take      = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      rem      <= take ? rem_shift - {1'b0, den} : rem_shift;
      quotient <= {quotient[NW-2:0], take};
    end
  end

endmodule

[src/cfm_isqrt.sv]
// ----------------------------------------------------------------------------
// cfm_isqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfm_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cfm_pkg::SQ_IN_W-1:0] value,
  output logic                        done,
  output logic [cfm_pkg::SQ_W-1:0]    root
);

  localparam int IW    = cfm_pkg::SQ_IN_W;
  localparam int RW    = cfm_pkg::SQ_W;
  localparam int CNT_W = $clog2(RW + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [IW-1:0]    val;
  logic [RW:0]      rem;
  logic [RW+1:0]    rem_shift;
  logic [RW+1:0]    trial;
  logic [RW+1:0]    diff;
  logic             take;

  assign rem_shift = {rem[RW-1:0], val[IW-1:IW-2]};
  assign trial     = {root, 2'b01};
  assign diff      = rem_shift - trial;
  assign take      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(RW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[IW-3:0], 2'b00};
      rem  <= take ? diff[RW:0] : rem_shift[RW:0];
      root <= {root[RW-2:0], take};
    end
  end

endmodule

[src/cfm_line_buffer.sv]
// ----------------------------------------------------------------------------
// cfm_line_buffer
// Line memory: luma of the two previous rows and features of the center row.
// ----------------------------------------------------------------------------
module cfm_line_buffer (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [cfm_pkg::ADDR_W-1:0]    rd_addr,
  output cfm_pkg::cfm_line_word_t       rd_data,
  input  logic                          wr_en,
  input  logic [cfm_pkg::ADDR_W-1:0]    wr_addr,
  input  cfm_pkg::cfm_line_word_t       wr_data
);

  cfm_pkg::cfm_line_word_t mem [cfm_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/cfm_feature.sv]
// ----------------------------------------------------------------------------
// cfm_feature
// Per-pixel luma, saturation and skin scores on a shared divider and root.
// ----------------------------------------------------------------------------
module cfm_feature (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  cfm_pkg::cfm_cfg_t cfg,
  output logic              done,
  output cfm_pkg::cfm_feat_t feat
);

  localparam int F   = cfm_pkg::FRAC_BITS;
  localparam int LSW = cfm_pkg::LUMA_SUM_W;
  localparam int M2W = cfm_pkg::M2_W;
  localparam int DTW = cfm_pkg::DOT_W;
  localparam int NW  = cfm_pkg::DIV_NW;
  localparam int DW  = cfm_pkg::DIV_DW;
  localparam int IW  = cfm_pkg::SQ_IN_W;
  localparam int D2W = cfm_pkg::D2_W;
  localparam int UW  = cfm_pkg::U_W;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MIX,
    F_NORM,
    F_SAT_DIV,
    F_SAT_RESCALE,
    F_SAT_RESCALE_DIV,
    F_SKIN,
    F_MAG,
    F_COS,
    F_DIST,
    F_SKIN_CHECK,
    F_SKIN_DIV
  } fstate_t;

  fstate_t state;

  logic [7:0]      r_q, g_q, b_q;
  logic [7:0]      mx, mn, mx_next, mn_next;
  logic [7:0]      sat_raw;
  logic [LSW-1:0]  luma_sum;
  logic [7:0]      luma_next;
  logic [M2W-1:0]  m2, m2_next;
  logic [DTW-1:0]  dot, dot_next;
  logic [7:0]      sat_d;
  logic [8:0]      sat_sum, sat_span;
  logic [7:0]      sat_den;
  logic [15:0]     sat_num;
  logic [7:0]      resc_d;
  logic [15:0]     resc_num;
  logic            sat_win, skin_win, sat_pass;
  logic [D2W-1:0]  d2;
  logic [F+2:0]    s_next;
  logic [F:0]      s_q;
  logic [F+8:0]    s255, tq, s_margin;
  logic [7:0]      q_capped;

  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_q;
  logic [DW-1:0]   div_den;
  logic            sq_start, sq_done;
  logic [IW-1:0]   sq_in;
  logic [cfm_pkg::SQ_W-1:0] sq_root;

  cfm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  cfm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_comb begin
    luma_sum = LSW'(cfm_pkg::LUMA_WR_Q) * LSW'(r_q)
             + LSW'(cfm_pkg::LUMA_WG_Q) * LSW'(g_q)
             + LSW'(cfm_pkg::LUMA_WB_Q) * LSW'(b_q);
    luma_next = (|luma_sum[LSW-1:F+8]) ? 8'hFF : luma_sum[F+7:F];

    mx_next = r_q;
    mn_next = r_q;
    if (g_q > mx_next) mx_next = g_q;
    if (b_q > mx_next) mx_next = b_q;
    if (g_q < mn_next) mn_next = g_q;
    if (b_q < mn_next) mn_next = b_q;

    m2_next = M2W'({8'd0, r_q} * {8'd0, r_q})
            + M2W'({8'd0, g_q} * {8'd0, g_q})
            + M2W'({8'd0, b_q} * {8'd0, b_q});
    dot_next = DTW'(cfm_pkg::SKIN_KR_Q) * DTW'(r_q)
             + DTW'(cfm_pkg::SKIN_KG_Q) * DTW'(g_q)
             + DTW'(cfm_pkg::SKIN_KB_Q) * DTW'(b_q);

    // hsl saturation: span over lightness distance to black or white
    sat_d    = mx - mn;
    sat_sum  = {1'b0, mx} + {1'b0, mn};
    sat_span = 9'd510 - sat_sum;
    sat_den  = (sat_sum <= 9'd255) ? sat_sum[7:0] : sat_span[7:0];
    sat_num  = {sat_d, 8'd0} - {8'd0, sat_d};

    sat_win  = (feat.luma >= cfg.sat_luma_min) && (feat.luma <= cfg.sat_luma_max);
    skin_win = (feat.luma >= cfg.skin_luma_min) && (feat.luma <= cfg.skin_luma_max);
    sat_pass = sat_win && (cfg.sat_threshold != 8'hFF) && (sat_raw > cfg.sat_threshold);
    resc_d   = sat_raw - cfg.sat_threshold;
    resc_num = {resc_d, 8'd0} - {8'd0, resc_d};

    // squared distance from the skin direction, negative clamps to zero
    d2 = D2W'(cfm_pkg::KK_PLUS_ONE_Q) - D2W'({div_q[UW-1:0], 1'b0});

    s_next   = (F+3)'(cfm_pkg::ONE_Q) - (F+3)'(sq_root[F+1:0]);
    s255     = {s_q, 8'd0} - (F+9)'(s_q);
    tq       = (F+9)'({cfg.skin_threshold, {F{1'b0}}});
    s_margin = s255 - tq;

    q_capped = (|div_q[NW-1:8]) ? 8'hFF : div_q[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            r_q   <= red;
            g_q   <= green;
            b_q   <= blue;
            state <= F_MIX;
          end
        end
        F_MIX: begin
          feat.luma <= luma_next;
          mx        <= mx_next;
          mn        <= mn_next;
          state     <= F_NORM;
        end
        F_NORM: begin
          m2  <= m2_next;
          dot <= dot_next;
          if (sat_d == 8'd0) begin
            sat_raw <= 8'd0;
            state   <= F_SAT_RESCALE;
          end else begin
            div_start <= 1'b1;
            div_num   <= NW'(sat_num);
            div_den   <= DW'(sat_den);
            state     <= F_SAT_DIV;
          end
        end
        F_SAT_DIV: begin
          if (div_done) begin
            sat_raw <= q_capped;
            state   <= F_SAT_RESCALE;
          end
        end
        F_SAT_RESCALE: begin
          if (sat_pass) begin
            div_start <= 1'b1;
            div_num   <= NW'(resc_num);
            div_den   <= DW'(8'hFF - cfg.sat_threshold);
            state     <= F_SAT_RESCALE_DIV;
          end else begin
            feat.sat <= 8'd0;
            state    <= F_SKIN;
          end
        end
        F_SAT_RESCALE_DIV: begin
          if (div_done) begin
            feat.sat <= q_capped;
            state    <= F_SKIN;
          end
        end
        F_SKIN: begin
          // black pixel has no direction
          if (m2 == '0 || !skin_win || cfg.skin_threshold == 8'hFF) begin
            feat.skin <= 8'd0;
            done      <= 1'b1;
            state     <= F_IDLE;
          end else begin
            sq_start <= 1'b1;
            sq_in    <= IW'({m2, {(2 * F){1'b0}}});
            state    <= F_MAG;
          end
        end
        F_MAG: begin
          if (sq_done) begin
            div_start <= 1'b1;
            div_num   <= NW'({dot, {F{1'b0}}});
            div_den   <= DW'(sq_root);
            state     <= F_COS;
          end
        end
        F_COS: begin
          if (div_done) begin
            sq_start <= 1'b1;
            sq_in    <= d2[D2W-1] ? '0 : IW'({d2[F+1:0], {F{1'b0}}});
            state    <= F_DIST;
          end
        end
        F_DIST: begin
          if (sq_done) begin
            if (s_next[F+2] || s_next == '0) begin
              feat.skin <= 8'd0;
              done      <= 1'b1;
              state     <= F_IDLE;
            end else begin
              s_q   <= s_next[F:0];
              state <= F_SKIN_CHECK;
            end
          end
        end
        F_SKIN_CHECK: begin
          if (s255 > tq) begin
            div_start <= 1'b1;
            div_num   <= NW'({s_margin, 8'd0}) - NW'(s_margin);
            div_den   <= DW'({8'hFF - cfg.skin_threshold, {F{1'b0}}});
            state     <= F_SKIN_DIV;
          end else begin
            feat.skin <= 8'd0;
            done      <= 1'b1;
            state     <= F_IDLE;
          end
        end
        F_SKIN_DIV: begin
          if (div_done) begin
            feat.skin <= q_capped;
            done      <= 1'b1;
            state     <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[src/crop_feature_map.sv]
// ----------------------------------------------------------------------------
// crop_feature_map
// Streaming feature map (edge, saturation, skin) for content-aware cropping.
// ----------------------------------------------------------------------------
// latency: a result appears one row and one pixel after its pixel
// throughput: one item at a time; a pixel's time is set by
//   the bit-serial divider (39 steps, up to four uses) and root (24 steps, twice)
// a drain item skips the feature unit, and is dropped when it comes mid-frame;
//   a pixel that fails its gates early skips the later divider and root steps
// reset: counters cleared, registers to defaults, line memory left unwritten
module crop_feature_map (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        drain,
  // feature output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  skin_score,
  output logic [7:0]  edge_score,
  output logic [7:0]  sat_score,
  output logic        end_of_frame,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int COL_W = cfm_pkg::COL_W;
  localparam int ROW_W = cfm_pkg::ROW_W;
  localparam int AW    = cfm_pkg::ADDR_W;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t state;

  // configuration
  logic [11:0]       image_width;
  logic [15:0]       image_height;
  cfm_pkg::cfm_cfg_t cfg;
  logic [COL_W-1:0]  width_eff;
  logic [ROW_W-1:0]  height_eff;

  // frame position of the next input and of the next output
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  out_x;
  logic [ROW_W-1:0]  out_y;

  // item in flight
  logic              pixel_q;
  logic              feat_done_q;
  logic [AW-1:0]     addr_q;

  // 3x3 window (cross taps) and feature of the center pixel
  logic [7:0]        win_up, win_mid, win_left, win_down;
  logic [15:0]       win_feat;

  logic              in_fire, pixel_now, take_item;
  logic              feat_start, feat_done;
  cfm_pkg::cfm_feat_t feat;
  cfm_pkg::cfm_line_word_t line_rd, line_wr;

  logic              emit, inner, eof, commit;
  logic [9:0]        lap_pos, lap_neg, lap_diff;
  logic [7:0]        edge_val;
  logic [COL_W-1:0]  col_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign pixel_now = row < height_eff;
  // a drain while the frame still arrives is dropped with no result
  assign take_item  = in_fire && !(pixel_now && drain);
  assign feat_start = take_item && pixel_now;

  always_comb begin
    if (image_width > 12'(cfm_pkg::MAX_WIDTH)) begin
      width_eff = COL_W'(cfm_pkg::MAX_WIDTH);
    end else if (image_width < 12'd3) begin
      width_eff = COL_W'(3);
    end else begin
      width_eff = COL_W'(image_width);
    end
    height_eff = (image_height < 16'd3) ? ROW_W'(3) : image_height;
  end

  cfm_line_buffer u_line_buffer (
    .clk     (clk),
    .rd_en   (take_item),
    .rd_addr (col[AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (commit && pixel_q),
    .wr_addr (addr_q),
    .wr_data (line_wr)
  );

  cfm_feature u_feature (
    .clk   (clk),
    .rst   (rst),
    .start (feat_start),
    .red   (red),
    .green (green),
    .blue  (blue),
    .cfg   (cfg),
    .done  (feat_done),
    .feat  (feat)
  );

  // the rows shift down by one: center luma moves to the above line
  always_comb begin
    line_wr.above  = line_rd.center;
    line_wr.center = feat.luma;
    line_wr.skin   = feat.skin;
    line_wr.sat    = feat.sat;
  end

  always_comb begin
    emit  = (row >= ROW_W'(2)) || (row == ROW_W'(1) && col >= COL_W'(1));
    inner = (out_x >= COL_W'(1))
         && (({1'b0, out_x} + (COL_W+1)'(2)) <= {1'b0, width_eff})
         && (out_y >= ROW_W'(1))
         && (({1'b0, out_y} + (ROW_W+1)'(2)) <= {1'b0, height_eff});
    eof   = emit && (out_x == width_eff - 1'b1) && (out_y == height_eff - 1'b1);

    // laplacian: 4 * center minus up, left, right (fresh center read) and down
    lap_pos  = {win_mid, 2'b00};
    lap_neg  = 10'(win_up) + 10'(win_left) + 10'(line_rd.center) + 10'(win_down);
    lap_diff = lap_pos - lap_neg;
    if (!inner) begin
      edge_val = win_mid;
    end else if (lap_neg >= lap_pos) begin
      edge_val = 8'd0;
    end else if (|lap_diff[9:8]) begin
      edge_val = 8'hFF;
    end else begin
      edge_val = lap_diff[7:0];
    end

    // wait for the features, and for room in the output register
    commit = (state == ST_BUSY) && (!pixel_q || feat_done_q)
          && !(emit && out_valid && out_stall);
    col_inc = col + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      feat_done_q        <= 1'b0;
      pixel_q            <= 1'b0;
      col                <= '0;
      row                <= '0;
      out_x              <= '0;
      out_y              <= '0;
      image_width        <= 12'd640;
      image_height       <= 16'd480;
      cfg.sat_threshold  <= 8'd102;
      cfg.skin_threshold <= 8'd204;
      cfg.sat_luma_min   <= 8'd13;
      cfg.sat_luma_max   <= 8'd230;
      cfg.skin_luma_min  <= 8'd51;
      cfg.skin_luma_max  <= 8'd255;
    end else begin
      // a new result may replace one taken in the same cycle
      if (commit && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (take_item) begin
            pixel_q     <= pixel_now;
            feat_done_q <= 1'b0;
            addr_q      <= col[AW-1:0];
            state       <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (feat_done) begin
            feat_done_q <= 1'b1;
          end
          if (commit) begin
            if (emit) begin
              skin_score   <= win_feat[15:8];
              sat_score    <= win_feat[7:0];
              edge_score   <= edge_val;
              end_of_frame <= eof;
            end
            // last output of the frame restarts the counters
            if (eof) begin
              col   <= '0;
              row   <= '0;
              out_x <= '0;
              out_y <= '0;
            end else begin
              if (emit) begin
                if (out_x == width_eff - 1'b1) begin
                  out_x <= '0;
                  out_y <= out_y + 1'b1;
                end else begin
                  out_x <= out_x + 1'b1;
                end
              end
              if (col_inc >= width_eff) begin
                col <= '0;
                if (row < height_eff) begin
                  row <= row + 1'b1;
                end
              end else begin
                col <= col_inc;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // write registers only while idle (unchecked); a new size restarts the frame
      if (cfg_valid && cfg_ready) begin
        unique case (cfm_pkg::cfm_reg_t'(cfg_index))
          cfm_pkg::REG_IMAGE_WIDTH: begin
            image_width <= cfg_data[11:0];
            col         <= '0;
            row         <= '0;
            out_x       <= '0;
            out_y       <= '0;
          end
          cfm_pkg::REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data;
            col          <= '0;
            row          <= '0;
            out_x        <= '0;
            out_y        <= '0;
          end
          cfm_pkg::REG_SAT_THRESHOLD:  cfg.sat_threshold  <= cfg_data[7:0];
          cfm_pkg::REG_SKIN_THRESHOLD: cfg.skin_threshold <= cfg_data[7:0];
          cfm_pkg::REG_SAT_LUMA_MIN:   cfg.sat_luma_min   <= cfg_data[7:0];
          cfm_pkg::REG_SAT_LUMA_MAX:   cfg.sat_luma_max   <= cfg_data[7:0];
          cfm_pkg::REG_SKIN_LUMA_MIN:  cfg.skin_luma_min  <= cfg_data[7:0];
          cfm_pkg::REG_SKIN_LUMA_MAX:  cfg.skin_luma_max  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // window shift at each committed item
  always_ff @(posedge clk) begin
    if (commit) begin
      win_left <= win_mid;
      win_mid  <= line_rd.center;
      win_up   <= line_rd.above;
      win_down <= pixel_q ? feat.luma : 8'd0;
      win_feat <= {line_rd.skin, line_rd.sat};
    end
  end

endmodule
